[hdl/nrmc_pkg.sv]
package nrmc_pkg;

	localparam int MINUTE_FRAC_DIGITS_DEF = 4;
	// the fixed-point minute fraction always holds four decimals
	localparam int FRAC_WEIGHT_DIGITS = 4;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_V      = 8'h56;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_W      = 8'h57;

	localparam logic [2:0] HDR_LAST = 3'd4;

	// field number, counted in commas after the header
	localparam logic [2:0] FLD_STATUS = 3'd2;
	localparam logic [2:0] FLD_LAT    = 3'd3;
	localparam logic [2:0] FLD_NS     = 3'd4;
	localparam logic [2:0] FLD_LON    = 3'd5;
	localparam logic [2:0] FLD_EW     = 3'd6;
	localparam logic [2:0] FLD_LAST   = 3'd7;

	localparam logic [3:0] LAT_DEG_DIGITS = 4'd2;
	localparam logic [3:0] LON_DEG_DIGITS = 4'd3;
	localparam logic [3:0] FCI_MAX        = 4'd15;

	localparam logic [7:0]  DEG_MAX       = 8'd255;
	localparam logic [6:0]  MIN_INT_MAX   = 7'd99;
	localparam logic [27:0] UNITS_PER_DEG = 28'd600000;
	localparam logic [27:0] UNITS_PER_MIN = 28'd10000;
	localparam logic [26:0] LAT_MAX       = 27'd54000000;
	localparam logic [27:0] LON_MAX       = 28'd108000000;

	typedef struct packed {
		logic [7:0]  deg;
		logic [6:0]  min_int;
		logic [13:0] min_frac;
		logic        dot;
		logic        stop;
	} acc_t;

	function automatic logic [7:0] hdr_char(input logic [2:0] idx);
		case (idx)
			3'd0: hdr_char = 8'h47; // G
			3'd1: hdr_char = 8'h50; // P
			3'd2: hdr_char = 8'h52; // R
			3'd3: hdr_char = 8'h4D; // M
			3'd4: hdr_char = 8'h43; // C
			default: hdr_char = 8'h00;
		endcase
	endfunction

	function automatic logic [13:0] frac_weight(input logic [1:0] pos);
		case (pos)
			2'd0: frac_weight = 14'd1000;
			2'd1: frac_weight = 14'd100;
			2'd2: frac_weight = 14'd10;
			2'd3: frac_weight = 14'd1;
			default: frac_weight = 14'd0;
		endcase
	endfunction

endpackage

[hdl/nrmc_in_if.sv]
interface nrmc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source(output valid, output char_in, input ready);
	modport sink(input valid, input char_in, output ready);
endinterface

[hdl/nrmc_out_if.sv]
interface nrmc_out_if;
	logic               valid;
	logic               ready;
	logic               has_fix_flag;
	logic               position_valid;
	logic signed [26:0] latitude;
	logic signed [27:0] longitude;

	modport source(output valid, output has_fix_flag, output position_valid,
		output latitude, output longitude, input ready);
	modport sink(input valid, input has_fix_flag, input position_valid,
		input latitude, input longitude, output ready);
endinterface

[hdl/nrmc_mag.sv]
module nrmc_mag
	import nrmc_pkg::*;
(
	input  acc_t        acc,
	output logic [26:0] lat_mag,
	output logic [27:0] lon_mag
);

	logic [27:0] deg_part;
	logic [27:0] min_part;
	logic [27:0] raw;

	// exact sum deg*600000 + minutes*10000 + four-decimal fraction
	assign deg_part = 28'(acc.deg) * UNITS_PER_DEG;
	assign min_part = 28'(acc.min_int) * UNITS_PER_MIN;
	assign raw      = deg_part + min_part + 28'(acc.min_frac);

	assign lat_mag = (raw > 28'(LAT_MAX)) ? LAT_MAX : raw[26:0];
	assign lon_mag = (raw > LON_MAX) ? LON_MAX : raw;

endmodule

[hdl/nmea_rmc_position_parser.sv]
// channel   dir  transfer when        payload
// char_ch   in   valid && ready       char_in[7:0]
// res_ch    out  valid && ready       has_fix_flag, position_valid, latitude[26:0],
//                                     longitude[27:0]
// one byte per cycle while the result register does not stall: a byte is first held in the
// input register, then updates the parse state and, on status 'V' or the E/W character,
// loads the result register; result valid is driven from that register, so a result
// passes through the input register and then the result register before its transfer
// arst_n clears the parse state, fix flag and both valid bits
// a stalled result register holds the byte in the input register, and no byte is taken
// while that register is full; an empty input register still takes one byte
module nmea_rmc_position_parser
	import nrmc_pkg::*;
#(
	parameter int MINUTE_FRAC_DIGITS = MINUTE_FRAC_DIGITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	nrmc_in_if.sink     char_ch,
	nrmc_out_if.source  res_ch
);

	localparam int FDW = $clog2(MINUTE_FRAC_DIGITS + 1);
	localparam logic [FDW-1:0] FD_MAX = FDW'(MINUTE_FRAC_DIGITS);

	logic       v_s1;
	logic [7:0] char_s1;
	logic       adv;
	logic       fire;

	logic [1:0]     phase_q, phase_d;
	logic [2:0]     hidx_q, hidx_d;
	logic [2:0]     comma_q, comma_d;
	logic [3:0]     fci_q, fci_d;
	acc_t           acc_q, acc_d, acc_nx;
	logic [FDW-1:0] fd_q, fd_d, fd_nx;
	logic signed [26:0] pend_q, pend_d;
	logic           fix_q, fix_d;

	logic               res_v_q;
	logic               res_fix_q;
	logic               res_pos_q;
	logic signed [26:0] res_lat_q;
	logic signed [27:0] res_lon_q;

	logic               emit;
	logic               emit_fix;
	logic               emit_pos;
	logic signed [26:0] emit_lat;
	logic signed [27:0] emit_lon;
	logic               bump;

	logic        is_dig;
	logic [3:0]  dval;
	logic [3:0]  deg_lim;
	logic [9:0]  deg10;
	logic [9:0]  min10;
	logic [13:0] frac_add;
	logic [26:0] lat_mag;
	logic [27:0] lon_mag;
	logic signed [27:0] lon_s;

	assign adv          = !res_v_q || res_ch.ready;
	assign char_ch.ready = !v_s1 || adv;
	assign fire         = v_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (char_ch.ready) begin
			v_s1 <= char_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ch.ready) begin
			char_s1 <= char_ch.char_in;
		end
	end

	nrmc_mag u_mag (
		.acc     (acc_q),
		.lat_mag (lat_mag),
		.lon_mag (lon_mag)
	);

	assign lon_s = signed'(lon_mag);

	// one character step of a coordinate field
	always_comb begin
		is_dig   = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
		dval     = is_dig ? 4'(char_s1 - CH_ZERO) : 4'd0;
		deg_lim  = (comma_q == FLD_LON) ? LON_DEG_DIGITS : LAT_DEG_DIGITS;
		deg10    = 10'(acc_q.deg) * 10'd10 + 10'(dval);
		min10    = 10'(acc_q.min_int) * 10'd10 + 10'(dval);
		frac_add = acc_q.min_frac + 14'(dval) * frac_weight(2'(fd_q));
		acc_nx   = acc_q;
		fd_nx    = fd_q;
		if (fci_q < deg_lim) begin
			acc_nx.deg = (deg10 > 10'(DEG_MAX)) ? DEG_MAX : deg10[7:0];
		end else if (!acc_q.stop) begin
			if (is_dig) begin
				if (!acc_q.dot) begin
					acc_nx.min_int = (min10 > 10'(MIN_INT_MAX)) ? MIN_INT_MAX : min10[6:0];
				end else if (fd_q < FD_MAX) begin
					// decimals past the fourth, up to MINUTE_FRAC_DIGITS, are counted but carry no weight
					if (32'(fd_q) < FRAC_WEIGHT_DIGITS) begin
						acc_nx.min_frac = frac_add;
					end
					fd_nx = fd_q + 1'b1;
				end
			end else if (char_s1 == CH_DOT && !acc_q.dot) begin
				acc_nx.dot = 1'b1;
			end else begin
				acc_nx.stop = 1'b1;
			end
		end
	end

	always_comb begin
		phase_d  = phase_q;
		hidx_d   = hidx_q;
		comma_d  = comma_q;
		fci_d    = fci_q;
		acc_d    = acc_q;
		fd_d     = fd_q;
		pend_d   = pend_q;
		fix_d    = fix_q;
		emit     = 1'b0;
		emit_fix = 1'b0;
		emit_pos = 1'b0;
		emit_lat = '0;
		emit_lon = '0;
		bump     = 1'b0;
		if (fire) begin
			if (char_s1 == CH_DOLLAR) begin
				phase_d = PH_HEADER;
				hidx_d  = '0;
				comma_d = '0;
				fci_d   = '0;
				acc_d   = '0;
				fd_d    = '0;
			end else if (phase_q == PH_HEADER) begin
				if (hidx_q <= HDR_LAST && char_s1 == hdr_char(hidx_q)) begin
					hidx_d = hidx_q + 3'd1;
					if (hidx_q == HDR_LAST) begin
						phase_d = PH_BODY;
					end
				end else begin
					phase_d = PH_IDLE;
				end
			end else if (phase_q == PH_BODY) begin
				if (char_s1 == CH_COMMA) begin
					if (comma_q == FLD_LAT) begin
						pend_d = signed'(lat_mag);
					end
					if (comma_q == FLD_STATUS || comma_q == FLD_NS) begin
						acc_d = '0;
						fd_d  = '0;
					end
					if (comma_q != FLD_LAST) begin
						comma_d = comma_q + 3'd1;
					end
					fci_d = '0;
				end else begin
					bump = 1'b1;
					case (comma_q)
						FLD_STATUS: begin
							if (char_s1 == CH_V) begin
								fix_d   = 1'b0;
								phase_d = PH_IDLE;
								emit    = 1'b1;
								bump    = 1'b0;
							end else begin
								fix_d = 1'b1;
							end
						end
						FLD_LAT, FLD_LON: begin
							acc_d = acc_nx;
							fd_d  = fd_nx;
						end
						FLD_NS: begin
							if (fci_q == '0 && char_s1 == CH_S) begin
								pend_d = -pend_q;
							end
						end
						FLD_EW: begin
							emit     = 1'b1;
							emit_fix = fix_q;
							emit_pos = 1'b1;
							emit_lat = pend_q;
							emit_lon = (char_s1 == CH_W) ? -lon_s : lon_s;
							phase_d  = PH_IDLE;
							bump     = 1'b0;
						end
						default: ;
					endcase
					if (bump && fci_q != FCI_MAX) begin
						fci_d = fci_q + 4'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hidx_q  <= '0;
			comma_q <= '0;
			fci_q   <= '0;
			acc_q   <= '0;
			fd_q    <= '0;
			pend_q  <= '0;
			fix_q   <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			hidx_q  <= hidx_d;
			comma_q <= comma_d;
			fci_q   <= fci_d;
			acc_q   <= acc_d;
			fd_q    <= fd_d;
			pend_q  <= pend_d;
			fix_q   <= fix_d;
			if (emit) begin
				res_v_q <= 1'b1;
			end else if (res_ch.ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_fix_q <= emit_fix;
			res_pos_q <= emit_pos;
			res_lat_q <= emit_lat;
			res_lon_q <= emit_lon;
		end
	end

	assign res_ch.valid          = res_v_q;
	assign res_ch.has_fix_flag   = res_fix_q;
	assign res_ch.position_valid = res_pos_q;
	assign res_ch.latitude       = res_lat_q;
	assign res_ch.longitude      = res_lon_q;

`ifndef SYNTHESIS
	a_nofix_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && !res_pos_q |-> !res_fix_q && res_lat_q == '0 && res_lon_q == '0)
		else $error("no-fix result carries position data");

	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q |-> res_lat_q <= 27'sd54000000 && res_lat_q >= -27'sd54000000)
		else $error("latitude out of range");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(char_s1))
		else $error("input stage lost a byte under stall");

	a_fd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fd_q <= FD_MAX)
		else $error("decimal count past limit");
`endif

endmodule
